// ===== rtl/ready_queue_scheduler_macros.svh =====
`ifndef READY_QUEUE_SCHEDULER_MACROS_SVH
`define READY_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define RQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rqs_pkg.sv =====
`default_nettype none

package rqs_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W   = 8;
   localparam int LEN_W  = 16;
   localparam int TICK_W = 32;
   localparam int KEY_W  = LEN_W + 1;

   // request opcodes
   localparam logic [1:0] OP_ARRIVE   = 2'd0;
   localparam logic [1:0] OP_SCHEDULE = 2'd1;
   localparam logic [1:0] OP_FINISH   = 2'd2;

   // scheduling policies
   localparam logic [1:0] POL_FCFS  = 2'd0;
   localparam logic [1:0] POL_RR    = 2'd1;
   localparam logic [1:0] POL_SJF   = 2'd2;
   localparam logic [1:0] POL_PSRTF = 2'd3;

   // register indexes
   localparam logic [1:0] REG_POLICY     = 2'd0;
   localparam logic [1:0] REG_TIME_SLICE = 2'd1;

   localparam logic [KEY_W-1:0] KEY_NONE = {1'b1, {LEN_W{1'b0}}};

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] burst;
      logic [LEN_W-1:0] rem;
   } entry_type;

   // running minimum handed along the chain
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             found;
      entry_type        entry;
   } carry_type;

   // broadcast to every cell
   typedef struct packed {
      logic push;
      logic shift;
      logic key_rem;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/rqs_cell.sv =====
`default_nettype none

module rqs_cell
   import rqs_pkg::*;
#(
   parameter int DEPTH      = QUEUE_DEPTH_DEF,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W     = $clog2(DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire cell_cmd_type       cmd,
   input  wire entry_type          push_entry,
   input  wire entry_type          right_entry,
   input  wire logic [CNT_W-1:0]   count,
   input  wire logic [IDX_W-1:0]   shift_idx,
   input  wire carry_type          carry_in,
   input  wire logic [IDX_W-1:0]   carry_idx_in,
   output carry_type               carry_out,
   output logic      [IDX_W-1:0]   carry_idx_out,
   output entry_type               entry_out
);

   localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   entry_type              entry_ff;
   carry_type              carry_ff;
   carry_type              carry_in_c;
   logic [IDX_W-1:0]       cidx_ff;
   logic [IDX_W-1:0]       cidx_in;
   logic                   occupied;
   logic [LEN_W-1:0]       key;
   logic                   wins;

   assign occupied = (MY_POS < count);
   assign key      = cmd.key_rem ? entry_ff.rem : entry_ff.burst;
   assign wins     = occupied && ({1'b0, key} < carry_in.key);

   // strict less-than: the earliest of equal keys keeps the carry
   always_comb begin
      carry_in_c = carry_in;
      cidx_in    = carry_idx_in;
      if (wins) begin
         carry_in_c.key   = {1'b0, key};
         carry_in_c.found = 1'b1;
         carry_in_c.entry = entry_ff;
         cidx_in          = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in_c;
      cidx_ff  <= cidx_in;
      if (cmd.push && (count == MY_POS)) begin
         entry_ff <= push_entry;
      end else if (cmd.shift && (MY_IDX >= shift_idx)) begin
         entry_ff <= right_entry;
      end
   end

   assign carry_out     = carry_ff;
   assign carry_idx_out = cidx_ff;
   assign entry_out     = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/rqs_chain.sv =====
`default_nettype none

module rqs_chain
   import rqs_pkg::*;
#(
   parameter int DEPTH  = QUEUE_DEPTH_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire cell_cmd_type     cmd,
   input  wire entry_type        push_entry,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic [IDX_W-1:0] shift_idx,
   input  wire carry_type        carry_init,
   output carry_type             carry_res,
   output logic      [IDX_W-1:0] carry_res_idx,
   output entry_type             head_entry
);

   entry_type           entries [DEPTH];
   carry_type           carries [DEPTH+1];
   logic [IDX_W-1:0]    cidx    [DEPTH+1];

   assign carries[0] = carry_init;
   assign cidx[0]    = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      entry_type right;
      if (g == DEPTH - 1) begin : g_last
         assign right = entries[g];
      end else begin : g_mid
         assign right = entries[g+1];
      end
      rqs_cell #(
         .DEPTH      (DEPTH),
         .CELL_INDEX (g)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .push_entry    (push_entry),
         .right_entry   (right),
         .count         (count),
         .shift_idx     (shift_idx),
         .carry_in      (carries[g]),
         .carry_idx_in  (cidx[g]),
         .carry_out     (carries[g+1]),
         .carry_idx_out (cidx[g+1]),
         .entry_out     (entries[g])
      );
   end

   assign carry_res     = carries[DEPTH];
   assign carry_res_idx = cidx[DEPTH];
   assign head_entry    = entries[0];

endmodule

`default_nettype wire

// ===== rtl/ready_queue_scheduler.sv =====
// Ready-queue scheduler: FCFS, round robin, shortest job, preemptive shortest remaining.
// req_ channel: one event per transfer; req_tuser carries the opcode (arrive,
// schedule at tick, finish), req_tdata the task and tick fields.
// rsp_ channel: exactly one status transfer per request, in request order.
// csr_ channel: register writes (policy, round robin slice), always ready;
// write only while no request is in flight.
// One request is handled at a time. Arrive, finish and a no-op schedule go
// from the decision straight to the response; a dispatch removes the chosen
// task from the queue, and shortest job and shortest remaining first run a
// minimum search. The minimum search runs as a running-minimum carry passed
// along the row of queue cells, one cell per cycle. Removal closes the gap
// with every cell from the victim onward taking its right-hand neighbour; a
// swapped-out task is written at the tail next.
// The result sits in an output register; a new request is taken while it waits,
// but that request's own result waits for the register to drain.
// Reset (synchronous, active high) empties the queue and running slot and
// restores policy FCFS with a slice of 4. No clearing pass is needed.
`default_nettype none

`include "ready_queue_scheduler_macros.svh"

module ready_queue_scheduler
   import rqs_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,  // task_id, task_burst, task_remaining,
                                        // tick, running_remaining
   input  wire logic [1:0]  req_tuser,  // opcode
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // switched, running_valid, running_id,
                                        // queue_count, dropped
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECIDE = 6'b000010,
      ST_SEARCH = 6'b000100,
      ST_SHIFT  = 6'b001000,
      ST_PUSH   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;

   // registers
   logic [1:0]         policy_ff;
   logic [LEN_W-1:0]   slice_ff;

   // latched request
   logic [1:0]         op_ff;
   entry_type          task_ff;
   logic [TICK_W-1:0]  tick_ff;
   logic [LEN_W-1:0]   rrem_ff;

   // running slot and queue fill
   logic               run_valid_ff, run_valid_in;
   entry_type          run_ff, run_in;
   logic [TICK_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // dispatch bookkeeping
   entry_type          sel_ff, sel_in;
   logic [IDX_W-1:0]   sel_idx_ff, sel_idx_in;
   logic               swap_ff, swap_in;
   entry_type          out_task_ff, out_task_in;
   logic [CNT_W-1:0]   search_cnt_ff, search_cnt_in;
   logic               switched_ff, switched_in;
   logic               dropped_ff, dropped_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_data_ff, rsp_data_in;

   // chain
   cell_cmd_type       cmd;
   entry_type          push_entry;
   carry_type          carry_init;
   carry_type          carry_res;
   logic [IDX_W-1:0]   carry_res_idx;
   entry_type          head_entry;

   logic               slice_hit;
   logic               rsp_free;
   logic [CNT_W+4:0]   count_wide;
   logic [ID_W-1:0]    id_shown;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // round robin expiry, modulo 2^32
   assign slice_hit = ((tick_ff - start_ff) == {{(TICK_W-LEN_W){1'b0}}, slice_ff});

   // preemptive search starts from the runner's remaining time; otherwise
   // any occupied cell beats the initial key
   always_comb begin
      carry_init       = '0;
      carry_init.key   = KEY_NONE;
      carry_init.entry = run_ff;
      if ((policy_ff == POL_PSRTF) && run_valid_ff) begin
         carry_init.key = {1'b0, run_ff.rem};
      end
   end

   rqs_chain #(
      .DEPTH (QUEUE_DEPTH)
   ) u_chain (
      .clock         (clock),
      .cmd           (cmd),
      .push_entry    (push_entry),
      .count         (count_ff),
      .shift_idx     (sel_idx_ff),
      .carry_init    (carry_init),
      .carry_res     (carry_res),
      .carry_res_idx (carry_res_idx),
      .head_entry    (head_entry)
   );

   assign count_wide = {5'b0, count_ff};
   assign id_shown   = run_valid_ff ? run_ff.id : '0;

   always_comb begin
      state_in      = state_ff;
      run_valid_in  = run_valid_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      sel_in        = sel_ff;
      sel_idx_in    = sel_idx_ff;
      swap_in       = swap_ff;
      out_task_in   = out_task_ff;
      search_cnt_in = search_cnt_ff;
      switched_in   = switched_ff;
      dropped_in    = dropped_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      cmd           = '0;
      cmd.key_rem   = (policy_ff == POL_PSRTF);
      push_entry    = task_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               switched_in = 1'b0;
               dropped_in  = 1'b0;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_DONE;
            case (op_ff)
               OP_ARRIVE: begin
                  if (count_ff < CNT_FULL) begin
                     cmd.push = 1'b1;
                     count_in = count_ff + 1'b1;
                  end else begin
                     dropped_in = 1'b1;
                  end
               end
               OP_SCHEDULE: begin
                  if (run_valid_ff) begin
                     run_in.rem = rrem_ff;
                  end
                  sel_in     = head_entry;
                  sel_idx_in = '0;
                  swap_in    = 1'b0;
                  if (count_ff != '0) begin
                     case (policy_ff)
                        POL_FCFS: begin
                           if (!run_valid_ff) begin
                              state_in = ST_SHIFT;
                           end
                        end
                        POL_RR: begin
                           if (!run_valid_ff) begin
                              state_in = ST_SHIFT;
                           end else if (slice_hit) begin
                              swap_in  = 1'b1;
                              state_in = ST_SHIFT;
                           end
                        end
                        POL_SJF: begin
                           if (!run_valid_ff) begin
                              search_cnt_in = '0;
                              state_in      = ST_SEARCH;
                           end
                        end
                        default: begin
                           search_cnt_in = '0;
                           state_in      = ST_SEARCH;
                        end
                     endcase
                  end
               end
               OP_FINISH: begin
                  run_valid_in = 1'b0;
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            // the result is taken once the carry has passed the register of every cell
            search_cnt_in = search_cnt_ff + 1'b1;
            if (search_cnt_ff == CNT_FULL) begin
               sel_in     = carry_res.entry;
               sel_idx_in = carry_res_idx;
               if (!run_valid_ff) begin
                  swap_in  = 1'b0;
                  state_in = ST_SHIFT;
               end else if (carry_res.found) begin
                  swap_in  = 1'b1;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SHIFT: begin
            cmd.shift    = 1'b1;
            count_in     = count_ff - 1'b1;
            out_task_in  = run_ff;
            run_in       = sel_ff;
            run_valid_in = 1'b1;
            start_in     = tick_ff;
            switched_in  = 1'b1;
            state_in     = swap_ff ? ST_PUSH : ST_DONE;
         end
         ST_PUSH: begin
            push_entry = out_task_ff;
            cmd.push   = 1'b1;
            count_in   = count_ff + 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {dropped_ff, count_wide[4:0], id_shown,
                               run_valid_ff, switched_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POL_FCFS;
         slice_ff     <= LEN_W'(4);
         run_valid_ff <= 1'b0;
         run_ff       <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_valid_ff <= run_valid_in;
         run_ff       <= run_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               REG_POLICY:     policy_ff <= csr_data[1:0];
               REG_TIME_SLICE: slice_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff         <= req_tuser;
         task_ff.id    <= req_tdata[7:0];
         task_ff.burst <= req_tdata[23:8];
         task_ff.rem   <= req_tdata[39:24];
         tick_ff       <= req_tdata[71:40];
         rrem_ff       <= req_tdata[87:72];
      end
      sel_ff        <= sel_in;
      sel_idx_ff    <= sel_idx_in;
      swap_ff       <= swap_in;
      out_task_ff   <= out_task_in;
      search_cnt_ff <= search_cnt_in;
      switched_ff   <= switched_in;
      dropped_ff    <= dropped_in;
      rsp_data_ff   <= rsp_data_in;
   end

   `RQS_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_FULL,
                   "queue fill beyond depth")
   `RQS_ASSERT_NOW(a_drop_full, clock, reset, rsp_valid_ff && rsp_data_ff[15],
                   rsp_data_ff[14:10] == 5'(QUEUE_DEPTH), "drop with room in queue")
   `RQS_ASSERT_NOW(a_switch_runs, clock, reset, rsp_valid_ff && rsp_data_ff[0],
                   rsp_data_ff[1], "switch reported with empty running slot")
   `RQS_ASSERT_NEXT(a_shift_dispatch, clock, reset, state_ff == ST_SHIFT,
                    run_valid_ff && switched_ff, "dispatch left running slot empty")

endmodule

`default_nettype wire
